>>> sv/digital_output_one_shot_bank_top_assert.svh
// assertion macros shared by the output bank modules
// both forms expect clk, and DOOSB_ASSERT also rst_n, in the enclosing module
`ifndef DIGITAL_OUTPUT_ONE_SHOT_BANK_TOP_ASSERT_SVH
`define DIGITAL_OUTPUT_ONE_SHOT_BANK_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define DOOSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DOOSB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DOOSB_ASSERT(label, prop, msg)

`define DOOSB_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> sv/doosb_pkg.sv
`timescale 1ns / 1ps

package doosb_pkg;

    localparam int DEFAULT_CHANNELS = 8;

    localparam int MODE_W  = 3;
    localparam int CHAN_W  = 8;
    localparam int TICK_W  = 16;
    localparam int PIN_W   = 8;

    localparam logic [MODE_W-1:0] MODE_SET    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_CHAN  = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] channel;
        logic              level;
        logic [TICK_W-1:0] pulse_ticks;
    } cmd_item_t;

    typedef struct packed {
        logic             status;
        logic             active_level;
        logic [PIN_W-1:0] pin_levels;
    } rsp_item_t;

endpackage

>>> sv/digital_output_one_shot_bank_top.sv
`timescale 1ns / 1ps

// bank of digital outputs with per-channel polarity and one-shot pulses.
// each request on the cmd channel sets, toggles, pulses or reads one
// channel, or advances time by one tick for all channels at once; every
// request gives exactly one response on the rsp channel, in order, with
// a status, the addressed channel's active level after the request and
// the physical level of the first eight pins after the invert mask.
// the bank takes one request per clock cycle for as long as rsp_stall is
// low; a request is held in the input register, then captured in the
// response register, and the channel state update for a request is done
// between those two registers.
// two requests can be held while rsp is stalled before cmd_stall rises.
// the invert mask is written on the cfg channel (always ready); the user
// must write it only while no request is in flight, which the block does
// not enforce. it acts at once on reported pin levels.
// nothing needs clearing after reset, so requests are taken right away.

`include "digital_output_one_shot_bank_top_assert.svh"

module digital_output_one_shot_bank_top
    import doosb_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
)
(
    input  logic             clk,
    input  logic             rst_n,

    // command requests
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_item_t        cmd,

    // responses
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_item_t        rsp,

    // invert mask writes
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [PIN_W-1:0] cfg_data
);

    // input stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    cmd_item_t        s1_reg;

    // response stage
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_item_t        rsp_reg;

    // polarity register
    logic [PIN_W-1:0] invert_mask_reg;
    logic [PIN_W-1:0] invert_mask_next;

    logic             take;
    logic             advance;
    rsp_item_t        bank_result;

    // the held request moves on whenever the response slot is free or draining
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);

    // stall only when both stages are full and the consumer holds back
    assign cmd_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;
    assign take      = cmd_valid && !cmd_stall;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next    = take || (s1_valid_reg && !advance);
        rsp_valid_next   = advance || (rsp_valid_reg && rsp_stall);
        invert_mask_next = (cfg_valid && cfg_ready) ? cfg_data : invert_mask_reg;
    end

    // channel state and the single-pass update
    doosb_bank #(
        .CHANNELS    (CHANNELS)
    ) u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (advance),
        .cmd         (s1_reg),
        .invert_mask (invert_mask_reg),
        .result      (bank_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            invert_mask_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            invert_mask_reg <= invert_mask_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg <= cmd;
        end
        if (advance)
        begin
            rsp_reg <= bank_result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a request that leaves the input stage shows up as a response next cycle
    `DOOSB_ASSERT(a_advance_gives_rsp, advance |=> rsp_valid, "processed request gave no response")
    // cmd is only held off when both stages are occupied
    `DOOSB_ASSERT(a_stall_when_full, !cmd_stall || (s1_valid_reg && rsp_valid_reg), "stall with a free stage")
    // a tick always answers ok with no meaningful level
    `DOOSB_ASSERT(a_tick_rsp_clean, (advance && (s1_reg.mode == MODE_TICK)) |=> (!rsp.status && !rsp.active_level), "tick response carries status or level")

endmodule

>>> sv/doosb_bank.sv
`timescale 1ns / 1ps

`include "digital_output_one_shot_bank_top_assert.svh"

module doosb_bank
    import doosb_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  cmd_item_t        cmd,
    input  logic [PIN_W-1:0] invert_mask,
    output rsp_item_t        result
);

    logic [CHANNELS-1:0] level_reg;
    logic [CHANNELS-1:0] level_next;
    logic [CHANNELS-1:0] run_reg;
    logic [CHANNELS-1:0] run_next;
    logic [TICK_W-1:0]   ticks_reg  [CHANNELS];
    logic [TICK_W-1:0]   ticks_next [CHANNELS];

    logic                in_range;
    logic [CHANNELS-1:0] hit;
    logic                addressed;
    logic [PIN_W-1:0]    pins;

    assign in_range = cmd.channel < CHAN_W'(CHANNELS);

    // per-channel update, all channels in parallel
    always_comb
    begin
        level_next = level_reg;
        run_next   = run_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            hit[c]        = in_range && (cmd.channel == CHAN_W'(c));
            ticks_next[c] = ticks_reg[c];
            if (go)
            begin
                case (cmd.mode)
                    MODE_SET:
                    begin
                        if (hit[c])
                        begin
                            level_next[c] = cmd.level;
                            run_next[c]   = 1'b0;
                            ticks_next[c] = '0;
                        end
                    end
                    MODE_TOGGLE:
                    begin
                        if (hit[c])
                        begin
                            level_next[c] = ~level_reg[c];
                            run_next[c]   = 1'b0;
                            ticks_next[c] = '0;
                        end
                    end
                    MODE_PULSE:
                    begin
                        if (hit[c])
                        begin
                            level_next[c] = 1'b1;
                            run_next[c]   = 1'b1;
                            ticks_next[c] = cmd.pulse_ticks;
                        end
                    end
                    MODE_TICK:
                    begin
                        if (run_reg[c])
                        begin
                            // a count of zero or one ends the pulse on this tick
                            if (ticks_reg[c] <= TICK_W'(1))
                            begin
                                level_next[c] = 1'b0;
                                run_next[c]   = 1'b0;
                                ticks_next[c] = '0;
                            end
                            else
                            begin
                                ticks_next[c] = ticks_reg[c] - TICK_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // only the first PIN_W channels reach the pin word
    for (genvar p = 0; p < PIN_W; p++)
    begin : g_pin
        if (p < CHANNELS)
        begin : g_live
            assign pins[p] = level_next[p] ^ invert_mask[p];
        end
        else
        begin : g_none
            assign pins[p] = 1'b0;
        end
    end

    assign addressed = (cmd.mode inside {MODE_SET, MODE_TOGGLE, MODE_PULSE, MODE_READ});

    always_comb
    begin
        result.status       = (addressed && !in_range) ? STATUS_BAD_CHAN : STATUS_OK;
        result.active_level = addressed && |(hit & level_next);
        result.pin_levels   = pins;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            run_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ticks_reg[c] <= '0;
            end
        end
        else
        begin
            level_reg <= level_next;
            run_reg   <= run_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                ticks_reg[c] <= ticks_next[c];
            end
        end
    end

    for (genvar a = 0; a < CHANNELS; a++)
    begin : g_chk
        // an idle channel never keeps a leftover count
        `DOOSB_ASSERT(a_idle_count_zero, run_reg[a] || (ticks_reg[a] == '0), "idle channel holds a count")
        // a timing pulse always drives the active level
        `DOOSB_ASSERT(a_running_is_active, !run_reg[a] || level_reg[a], "running pulse is not active")
    end

endmodule
